>>> src/ognd_pkg.sv
// shared constants and types for the octave gradient noise block
`default_nettype none
package ognd_pkg;
   localparam int PERM_SIZE   = 256;
   localparam int PERM_AW     = $clog2(PERM_SIZE);
   localparam int MAX_OCTAVES = 8;
   localparam int OCT_W       = $clog2(MAX_OCTAVES);
   localparam int FRAC_BITS   = 16;
   localparam int COORD_W     = 32;
   localparam int NOISE_W     = 19;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int GRAD_W      = 20;
   localparam int SUM_W       = 24;
   localparam int AMP_W       = 17;
   localparam int TOTAL_W     = 20;
   localparam int RECIP_W     = 33;
   localparam int DIV_STEPS   = 49;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
   localparam int NOISE_LIMIT = 196608;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_OCTAVE_COUNT = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PERSISTENCE  = 1'd1;

   // request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   typedef logic signed [GRAD_W-1:0] grad_type;
endpackage
`default_nettype wire

>>> src/ognd_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module ognd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/octave_gradient_noise_2d.sv
// Per octave an evaluate request steps through the table reads, gradient, the x and y
// blends and accumulation; then come the reciprocal divider (one quotient bit a cycle),
// scaling and output. One evaluation at a time: the next is accepted once the result
// enters the output register, which waits while an earlier result is held. An octave
// is bound by its six permutation reads (two ram copies, one read port each). Reset
// (synchronous, active high) restores state, valid flag and config; table not cleared.
`default_nettype none
module octave_gradient_noise_2d
   import ognd_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_action,
   input  wire logic signed [COORD_W-1:0]    req_x_coord,
   input  wire logic signed [COORD_W-1:0]    req_y_coord,
   input  wire logic [PERM_AW-1:0]           req_table_index,
   input  wire logic [PERM_AW-1:0]           req_table_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [NOISE_W-1:0]         rsp_noise_value,
   input  wire logic                         csr_we,
   input  wire logic [CSR_ADDR_W-1:0]        csr_addr,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_GR, ST_LX, ST_LY, ST_AC,
      ST_DIV, ST_MUL0, ST_MUL1, ST_OUT
   } state_type;

   state_type state_ff;

   logic [3:0]            octave_count_ff;
   logic [15:0]           persistence_ff;
   logic [23:0]           xs_ff, ys_ff;
   logic [3:0]            n_ff;
   logic [OCT_W-1:0]      oct_ff;
   logic [AMP_W-1:0]      amp_ff, amp_nx_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [31:0]           f2x_ff, f2y_ff, f3x_ff, f3y_ff;
   logic [19:0]           polyx_ff, polyy_ff;
   logic [AMP_W-1:0]      ux_ff, uy_ff;
   logic [PERM_AW-1:0]    ia_ff, ib_ff, h00_ff, h10_ff;
   grad_type              g00_ff, g10_ff, g01_ff, g11_ff, lx0_ff, lx1_ff, nv_ff;
   logic [TOTAL_W:0]      rem_ff;
   logic [RECIP_W-1:0]    q_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic signed [42:0]    plo_ff;
   logic signed [25:0]    res_ff;
   logic                  rsp_valid_ff;
   logic signed [NOISE_W-1:0] rsp_noise_ff;

   logic                  accept;
   logic                  ram_we;
   logic [PERM_AW-1:0]    addr_a, addr_b, rdata_a, rdata_b, ia_in, ib_in;
   logic [15:0]           fx, fy;
   logic signed [17:0]    fx0, fy0, fx1, fy1;
   logic [36:0]           polyx_in, polyy_in;
   logic [TOTAL_W:0]      rem_sh;
   logic                  q_bit;
   logic signed [37:0]    term_full;
   logic signed [57:0]    prod_in;
   logic signed [25:0]    res_in;
   logic [3:0]            n_in;

   // gradient selection with doubled second term
   function automatic grad_type grad(input logic [1:0] h, input logic signed [17:0] x,
                                     input logic signed [17:0] y);
      logic signed [GRAD_W-1:0] u, v, p, q;
      u = (h[1] == 1'b0) ? GRAD_W'(x) : GRAD_W'(y);
      v = (h[1] == 1'b0) ? GRAD_W'(y) : GRAD_W'(x);
      p = h[0] ? -u : u;
      q = h[1] ? -(v <<< 1) : (v <<< 1);
      return p + q;
   endfunction

   // linear blend a + floor(t*(b-a)/2^16)
   function automatic grad_type blend(input grad_type a, input grad_type b,
                                      input logic [AMP_W-1:0] t);
      logic signed [GRAD_W:0]   d;
      logic signed [GRAD_W+18:0] pr;
      d  = (GRAD_W+1)'(b) - (GRAD_W+1)'(a);
      pr = (GRAD_W+19)'($signed({1'b0, t})) * (GRAD_W+19)'(d);
      return a + GRAD_W'(pr >>> FRAC_BITS);
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign ram_we    = accept && (req_action == ACT_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   // lattice fractions and corner offsets
   assign fx  = xs_ff[15:0];
   assign fy  = ys_ff[15:0];
   assign fx0 = $signed({2'b00, fx});
   assign fy0 = $signed({2'b00, fy});
   assign fx1 = fx0 - 18'sd65536;
   assign fy1 = fy0 - 18'sd65536;

   // hashed row indexes
   assign ia_in = rdata_a + ys_ff[23:16];
   assign ib_in = rdata_b + ys_ff[23:16];

   // table read addresses
   always_comb begin
      case (state_ff)
         ST_RD0: begin
            addr_a = xs_ff[23:16];
            addr_b = xs_ff[23:16] + 8'd1;
         end
         ST_RD1: begin
            addr_a = ia_in;
            addr_b = ib_in;
         end
         default: begin
            addr_a = ia_ff + 8'd1;
            addr_b = ib_ff + 8'd1;
         end
      endcase
   end

   // fade polynomial in Q.32
   assign polyx_in = (37'd10 << 32) - (37'(20'd15 * fx) << 16) + 37'd6 * 37'(f2x_ff);
   assign polyy_in = (37'd10 << 32) - (37'(20'd15 * fy) << 16) + 37'd6 * 37'(f2y_ff);

   // divider step
   assign rem_sh = {rem_ff[TOTAL_W-1:0], (cnt_ff == CNT_W'(DIV_STEPS-1))};
   assign q_bit  = (rem_sh >= {1'b0, total_ff});

   // octave accumulation term
   assign term_full = 38'(nv_ff) * 38'($signed({1'b0, amp_ff}));

   // final scaling, upper partial product
   assign prod_in = ((58'(sum_ff) * 58'($signed({1'b0, q_ff[32:16]}))) <<< 16)
                    + 58'(plo_ff);
   assign res_in  = prod_in[57:32];

   // octave count clamp
   assign n_in = (octave_count_ff == 4'd0) ? 4'd1 :
                 (octave_count_ff > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octave_count_ff;

   ognd_ram #(.WIDTH(PERM_AW), .DEPTH(PERM_SIZE)) u_ram_a (
      .clock(clock), .wr_en(ram_we), .wr_addr(req_table_index), .wr_data(req_table_value),
      .rd_addr(addr_a), .rd_data(rdata_a)
   );
   ognd_ram #(.WIDTH(PERM_AW), .DEPTH(PERM_SIZE)) u_ram_b (
      .clock(clock), .wr_en(ram_we), .wr_addr(req_table_index), .wr_data(req_table_value),
      .rd_addr(addr_b), .rd_data(rdata_b)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= 4'd5;
         persistence_ff  <= 16'd29491;
      end else if (csr_we) begin
         case (csr_addr)
            REG_OCTAVE_COUNT: octave_count_ff <= csr_wdata[3:0];
            REG_PERSISTENCE:  persistence_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer, datapath and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_action == ACT_EVAL) begin
                  xs_ff    <= req_x_coord[23:0];
                  ys_ff    <= req_y_coord[23:0];
                  n_ff     <= n_in;
                  oct_ff   <= '0;
                  amp_ff   <= AMP_ONE;
                  total_ff <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: begin
               f2x_ff   <= 32'(fx) * 32'(fx);
               f2y_ff   <= 32'(fy) * 32'(fy);
               state_ff <= ST_RD1;
            end
            ST_RD1: begin
               ia_ff    <= ia_in;
               ib_ff    <= ib_in;
               f3x_ff   <= 32'((48'(f2x_ff) * 48'(fx)) >> 16);
               f3y_ff   <= 32'((48'(f2y_ff) * 48'(fy)) >> 16);
               polyx_ff <= polyx_in[35:16];
               polyy_ff <= polyy_in[35:16];
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               h00_ff   <= rdata_a;
               h10_ff   <= rdata_b;
               ux_ff    <= AMP_W'((52'(f3x_ff) * 52'(polyx_ff)) >> 32);
               uy_ff    <= AMP_W'((52'(f3y_ff) * 52'(polyy_ff)) >> 32);
               state_ff <= ST_GR;
            end
            ST_GR: begin
               g00_ff    <= grad(h00_ff[1:0], fx0, fy0);
               g10_ff    <= grad(h10_ff[1:0], fx1, fy0);
               g01_ff    <= grad(rdata_a[1:0], fx0, fy1);
               g11_ff    <= grad(rdata_b[1:0], fx1, fy1);
               amp_nx_ff <= AMP_W'((33'(amp_ff) * 33'(persistence_ff)) >> FRAC_BITS);
               state_ff  <= ST_LX;
            end
            ST_LX: begin
               lx0_ff   <= blend(g00_ff, g10_ff, ux_ff);
               lx1_ff   <= blend(g01_ff, g11_ff, ux_ff);
               state_ff <= ST_LY;
            end
            ST_LY: begin
               nv_ff    <= blend(lx0_ff, lx1_ff, uy_ff);
               state_ff <= ST_AC;
            end
            ST_AC: begin
               sum_ff   <= sum_ff + SUM_W'(term_full >>> FRAC_BITS);
               total_ff <= total_ff + TOTAL_W'(amp_ff);
               amp_ff   <= amp_nx_ff;
               xs_ff    <= xs_ff << 1;
               ys_ff    <= ys_ff << 1;
               oct_ff   <= oct_ff + 1'b1;
               if ({1'b0, oct_ff} == n_ff - 4'd1) begin
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= CNT_W'(DIV_STEPS-1);
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_RD0;
               end
            end
            ST_DIV: begin
               rem_ff <= q_bit ? (rem_sh - {1'b0, total_ff}) : rem_sh;
               q_ff   <= {q_ff[RECIP_W-2:0], q_bit};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= ST_MUL0;
               end
            end
            ST_MUL0: begin
               plo_ff   <= 43'(sum_ff) * 43'($signed({1'b0, q_ff[15:0]}));
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               res_ff   <= res_in;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (res_ff > 26'sd196608) begin
                     rsp_noise_ff <= NOISE_W'(NOISE_LIMIT);
                  end else if (res_ff < -26'sd196608) begin
                     rsp_noise_ff <= -NOISE_W'(NOISE_LIMIT);
                  end else begin
                     rsp_noise_ff <= NOISE_W'(res_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // a result appears only out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");
   // results stay inside the saturation range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_noise_ff <= 19'sd196608 && rsp_noise_ff >= -19'sd196608))
      else $error("result out of range");
   // table writes never overlap an evaluation
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("table write during evaluation");
   // reciprocal of a total in range lies above 2^29
   a_recip_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL0 |-> q_ff[32:29] != 4'd0)
      else $error("reciprocal out of range");
`endif
endmodule
`default_nettype wire
